/* src/deq_pkg.sv */
// shared types and codes for the double-ended queue
package deq_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LIST_BACK  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } result_t;

endpackage

/* src/deq_ring_store.sv */
// ring store: one write port, one read port with registered read data
module deq_ring_store import deq_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/double_ended_queue_core.sv */
// Bounded double-ended queue of signed 32-bit values held in a ring store.
// A beat is taken when start is high and busy is low. Push and pop keep busy
// low, so such items can follow every cycle; each gives one result on the
// cycle after it is taken. A listing of n entries reads the store once per
// entry through its single read port, emitting one entry per cycle starting
// the cycle after acceptance, and holds busy high until the last entry has
// been read. An empty listing gives one empty status result. Opcodes 6 and 7
// give no result. Results appear on result with result_valid for one cycle
// and cannot be stalled. No clearing pass is needed after reset.
module double_ended_queue_core import deq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    result_valid,
  output result_t result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t             state;
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   list_ptr;
  logic [CNT_W-1:0]   list_left;
  logic               list_back;
  logic [STATUS_W-1:0] rsp_status;
  logic               rsp_last;
  logic               rsp_from_mem;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [IDX_W-1:0]          back_idx;
  logic [IDX_W-1:0]          tail_idx;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  // ring arithmetic
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  assign busy     = (state == S_LIST);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign back_idx = ring_add(front, count - 1'b1);
  assign tail_idx = ring_add(front, count);

  // store access for the current beat or listing step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_idx;
    rd_en   = 1'b0;
    rd_addr = front;
    if (state == S_LIST) begin
      rd_en   = 1'b1;
      rd_addr = list_ptr;
    end else if (accept) begin
      case (cmd.opcode)
        OP_PUSH_FRONT: begin
          wr_en   = !full;
          wr_addr = ring_dec(front);
        end
        OP_PUSH_BACK: begin
          wr_en = !full;
        end
        OP_POP_FRONT, OP_LIST_FRONT: begin
          rd_en = !empty;
        end
        OP_POP_BACK, OP_LIST_BACK: begin
          rd_en   = !empty;
          rd_addr = back_idx;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
  end

  deq_ring_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control, ring pointers and registered result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      front        <= '0;
      count        <= '0;
      list_left    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_from_mem <= 1'b0;
            rsp_last     <= 1'b1;
            rsp_status   <= ST_OK;
            case (cmd.opcode)
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                result_valid <= 1'b1;
                if (full) begin
                  rsp_status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                  if (cmd.opcode == OP_PUSH_FRONT) begin
                    front <= ring_dec(front);
                  end
                end
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                result_valid <= 1'b1;
                if (empty) begin
                  rsp_status <= ST_EMPTY;
                end else begin
                  rsp_from_mem <= 1'b1;
                  count        <= count - 1'b1;
                  if (cmd.opcode == OP_POP_FRONT) begin
                    front <= ring_inc(front);
                  end
                end
              end
              OP_LIST_FRONT, OP_LIST_BACK: begin
                result_valid <= 1'b1;
                if (empty) begin
                  rsp_status <= ST_EMPTY;
                end else begin
                  rsp_from_mem <= 1'b1;
                  rsp_last     <= (count == CNT_W'(1));
                  list_left    <= count - 1'b1;
                  list_back    <= (cmd.opcode == OP_LIST_BACK);
                  list_ptr     <= (cmd.opcode == OP_LIST_BACK) ? ring_dec(back_idx)
                                                               : ring_inc(front);
                  if (count != CNT_W'(1)) begin
                    state <= S_LIST;
                  end
                end
              end
              default: begin
                result_valid <= 1'b0;
              end
            endcase
          end
        end
        S_LIST: begin
          result_valid <= 1'b1;
          rsp_from_mem <= 1'b1;
          rsp_status   <= ST_OK;
          rsp_last     <= (list_left == CNT_W'(1));
          list_left    <= list_left - 1'b1;
          list_ptr     <= list_back ? ring_dec(list_ptr) : ring_inc(list_ptr);
          if (list_left == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    result.out_value = rsp_from_mem ? rd_data : '0;
    result.status    = rsp_status;
    result.last      = rsp_last;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_list_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |=> (result_valid && result.status == ST_OK))
    else $error("listing step gave no ok result");

  a_list_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |=> $stable(count) && $stable(front))
    else $error("queue state moved during listing");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full &&
     (cmd.opcode == OP_PUSH_FRONT || cmd.opcode == OP_PUSH_BACK))
    |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the queue");

  a_list_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && list_left != CNT_W'(1)) |=> (state == S_LIST && !result.last))
    else $error("listing ended early");

endmodule
